[rtl/aac_rtp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AAC RTP depacketizer package
// Shared item types and constants for the byte-stream depacketizer.
// ----------------------------------------------------------------------------
package aac_rtp_pkg;

	localparam int LENGTH_WIDTH_DEF = 16;
	localparam int HDR_LEN_BYTES    = 2;
	localparam int BITS_PER_BYTE    = 8;
	localparam int BIT_ROUND_UP     = 7;
	localparam int SKIP_WIDTH       = 14;
	localparam int FRAME_LEN_WIDTH  = 16;
	localparam logic [32:0] FRAME_LEN_MAX = 33'd65535;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        packet_start;
		logic        packet_end;
		logic        marker_bit;
		logic [31:0] rtp_timestamp;
	} pkt_item_t;

	typedef struct packed {
		logic [7:0]                 out_byte;
		logic                       byte_valid;
		logic                       frame_end;
		logic                       frame_abort;
		logic [FRAME_LEN_WIDTH-1:0] frame_length;
	} frame_item_t;

endpackage
`default_nettype wire

[rtl/aac_rtp_pkt_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AAC RTP packet byte channel
// Valid/ready channel carrying one tagged RTP payload byte per transfer.
// ----------------------------------------------------------------------------
interface aac_rtp_pkt_if;
	import aac_rtp_pkg::*;

	logic      valid;
	logic      ready;
	pkt_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

[rtl/aac_rtp_frame_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AAC RTP frame byte channel
// Valid/ready channel carrying one frame result per transfer.
// ----------------------------------------------------------------------------
interface aac_rtp_frame_if;
	import aac_rtp_pkg::*;

	logic        valid;
	logic        ready;
	frame_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

[rtl/aac_rtp_depacketizer_unit.sv]
// Output: an input transfer that yields a result loads it into the output register.
// Throughput: one byte per cycle while the output register is empty or its result is
// taken; the output register accepts a new byte in the cycle its current result is taken.
// Reset: arst_n clears timestamp, header length, byte position, frame count
// and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AAC RTP depacketizer unit
// Skips the AU-header section of each packet and streams the frame payload
// with end and abort flags.
// ----------------------------------------------------------------------------
module aac_rtp_depacketizer_unit #(
	parameter int LENGTH_WIDTH = aac_rtp_pkg::LENGTH_WIDTH_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	aac_rtp_pkt_if.sink    pkt,
	aac_rtp_frame_if.source frame
);
	import aac_rtp_pkg::*;

	localparam int CMP_WIDTH = (LENGTH_WIDTH > SKIP_WIDTH) ? LENGTH_WIDTH : SKIP_WIDTH;
	localparam logic [LENGTH_WIDTH-1:0] COUNT_MAX = '1;

	logic [31:0]             ts_q;
	logic [15:0]             header_q;
	logic [LENGTH_WIDTH-1:0] pos_q;
	logic [LENGTH_WIDTH-1:0] fb_q;
	logic                    out_valid_q;
	frame_item_t             out_item_q;

	logic                    accept;
	pkt_item_t               in_item;
	logic [LENGTH_WIDTH-1:0] pos;
	logic                    aborted;
	logic                    payload;
	logic                    final_byte;
	logic [16:0]             hdr_round;
	logic [SKIP_WIDTH-1:0]   skip;
	logic [15:0]             header_next;
	logic [LENGTH_WIDTH-1:0] pos_next;
	logic [LENGTH_WIDTH-1:0] fb_base;
	logic [LENGTH_WIDTH-1:0] fb_inc;
	logic [LENGTH_WIDTH-1:0] fb_next;
	logic [32:0]             fb_wide;
	frame_item_t             result;
	logic                    result_valid;

	assign pkt.ready   = !out_valid_q || frame.ready;
	assign accept      = pkt.valid && pkt.ready;
	assign in_item     = pkt.item;
	assign frame.valid = out_valid_q;
	assign frame.item  = out_item_q;

	always_comb begin
		pos        = in_item.packet_start ? '0 : pos_q;
		aborted    = in_item.packet_start && (fb_q != '0) && (in_item.rtp_timestamp != ts_q);
		hdr_round  = {1'b0, header_q} + 17'(BIT_ROUND_UP);
		skip       = SKIP_WIDTH'(hdr_round >> $clog2(BITS_PER_BYTE)) + SKIP_WIDTH'(HDR_LEN_BYTES);
		payload    = (CMP_WIDTH'(pos) >= CMP_WIDTH'(HDR_LEN_BYTES))
			&& (CMP_WIDTH'(pos) >= CMP_WIDTH'(skip));
		final_byte = in_item.packet_end && in_item.marker_bit;

		header_next = header_q;
		if (pos == '0) begin
			header_next = {in_item.data_byte, 8'h00};
		end else if (pos == LENGTH_WIDTH'(1)) begin
			header_next = {header_q[15:8], in_item.data_byte};
		end

		pos_next = (pos == COUNT_MAX) ? pos : pos + 1'b1;
		fb_base  = aborted ? '0 : fb_q;
		fb_inc   = (payload && fb_base != COUNT_MAX) ? fb_base + 1'b1 : fb_base;
		fb_next  = final_byte ? '0 : fb_inc;
		fb_wide  = 33'(fb_inc);

		result_valid        = payload || final_byte || aborted;
		result.out_byte     = payload ? in_item.data_byte : 8'h00;
		result.byte_valid   = payload;
		result.frame_end    = final_byte;
		result.frame_abort  = aborted;
		result.frame_length = (fb_wide > FRAME_LEN_MAX) ? '1 : fb_wide[FRAME_LEN_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q     <= '0;
			header_q <= '0;
			pos_q    <= '0;
			fb_q     <= '0;
		end else if (accept) begin
			if (in_item.packet_start) begin
				ts_q <= in_item.rtp_timestamp;
			end
			header_q <= header_next;
			pos_q    <= pos_next;
			fb_q     <= fb_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pkt.ready) begin
			out_valid_q <= accept && result_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && result_valid) begin
			out_item_q <= result;
		end
	end

endmodule
`default_nettype wire

[sim/aac_rtp_depacketizer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AAC RTP depacketizer unit testbench
// Streams tagged RTP payload bytes into the unit and checks every frame
// result against a byte-level predictor of header skip, frame end, abort
// and saturating counts. The stimulus covers directed corner packets, random
// frames, broken and stray sequences, a long packet continued without a
// start, and back-pressure from both sides.
// ----------------------------------------------------------------------------
module aac_rtp_depacketizer_unit_tb;
	import aac_rtp_pkg::*;

	localparam int HOLD_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam logic [LENGTH_WIDTH_DEF-1:0] COUNT_MAX = {LENGTH_WIDTH_DEF{1'b1}};

	class frame_scoreboard;
		bit [31:0]                 held_ts;
		bit [15:0]                 hdr_bits;
		bit [LENGTH_WIDTH_DEF-1:0] byte_pos;
		bit [LENGTH_WIDTH_DEF-1:0] payload_cnt;
		frame_item_t               pending[$];
		int                        errors;

		function void note(pkt_item_t it);
			bit [LENGTH_WIDTH_DEF-1:0] pos;
			int unsigned               skip;
			bit                        aborted;
			bit                        payload;
			bit                        frame_done;
			frame_item_t               exp;
			pos = it.packet_start ? '0 : byte_pos;
			aborted = 1'b0;
			if (it.packet_start) begin
				if (payload_cnt != 0 && it.rtp_timestamp != held_ts) begin
					aborted = 1'b1;
					payload_cnt = '0;
				end
				held_ts = it.rtp_timestamp;
			end
			if (pos == 0)
				hdr_bits = {it.data_byte, 8'h00};
			else if (pos == 1)
				hdr_bits[7:0] = it.data_byte;
			skip = HDR_LEN_BYTES + ((int'(hdr_bits) + BIT_ROUND_UP) / BITS_PER_BYTE);
			payload = pos >= HDR_LEN_BYTES && pos >= skip;
			if (payload && payload_cnt != COUNT_MAX)
				payload_cnt++;
			byte_pos = (pos == COUNT_MAX) ? pos : pos + 1'b1;
			frame_done = it.packet_end && it.marker_bit;
			if (!(payload || frame_done || aborted))
				return;
			exp.out_byte = payload ? it.data_byte : 8'h00;
			exp.byte_valid = payload;
			exp.frame_end = frame_done;
			exp.frame_abort = aborted;
			exp.frame_length = (payload_cnt > FRAME_LEN_MAX) ? FRAME_LEN_MAX[FRAME_LEN_WIDTH-1:0]
				: FRAME_LEN_WIDTH'(payload_cnt);
			pending.push_back(exp);
			if (frame_done)
				payload_cnt = '0;
		endfunction

		function void mismatch(string field, longint unsigned exp_v, longint unsigned got_v);
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, got_v);
		endfunction

		function void check(frame_item_t got);
			frame_item_t exp;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got %h", $time, got);
				return;
			end
			exp = pending.pop_front();
			if (got.out_byte !== exp.out_byte)
				mismatch("out_byte", exp.out_byte, got.out_byte);
			if (got.byte_valid !== exp.byte_valid)
				mismatch("byte_valid", exp.byte_valid, got.byte_valid);
			if (got.frame_end !== exp.frame_end)
				mismatch("frame_end", exp.frame_end, got.frame_end);
			if (got.frame_abort !== exp.frame_abort)
				mismatch("frame_abort", exp.frame_abort, got.frame_abort);
			if (got.frame_length !== exp.frame_length)
				mismatch("frame_length", exp.frame_length, got.frame_length);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	aac_rtp_pkt_if   pkt_ch();
	aac_rtp_frame_if frame_ch();

	frame_scoreboard sb = new();

	int        sent_cnt;
	int        gap_pct;
	bit        quiet;
	bit        hold_req;
	bit [31:0] last_ts;
	int        stall_cnt;

	aac_rtp_depacketizer_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pkt(pkt_ch),
		.frame(frame_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pkt_ch.valid && pkt_ch.ready)
				sb.note(pkt_ch.item);
			if (frame_ch.valid && frame_ch.ready)
				sb.check(frame_ch.item);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pkt_ch.valid && pkt_ch.ready) || (frame_ch.valid && frame_ch.ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt == WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// frame receiver: random stalls, one long hold-off on request
	initial begin
		int cyc;
		int stall_pct;
		cyc = 0;
		stall_pct = 15;
		frame_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 64 == 0)
				stall_pct = 15 * $urandom_range(0, 2);
			if (hold_req) begin
				hold_req = 1'b0;
				frame_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
				frame_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				frame_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_byte(input logic [7:0] d, input logic s, input logic e,
			input logic m, input logic [31:0] ts);
		pkt_item_t it;
		it.data_byte = d;
		it.packet_start = s;
		it.packet_end = e;
		it.marker_bit = m;
		it.rtp_timestamp = ts;
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			pkt_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		pkt_ch.valid <= 1'b1;
		pkt_ch.item <= it;
		do @(posedge clk); while (!pkt_ch.ready);
		sent_cnt++;
	endtask

	task automatic send_packet(input logic [15:0] hdr, input int len, input logic m,
			input logic [31:0] ts);
		logic [7:0] d;
		for (int i = 0; i < len; i++) begin
			d = (i == 0) ? hdr[15:8] : (i == 1) ? hdr[7:0] : 8'($urandom);
			send_byte(d, i == 0, i == len - 1, m, ts);
		end
	endtask

	function automatic logic [31:0] next_ts();
		if ($urandom_range(0, 3) != 0)
			last_ts = $urandom;
		return last_ts;
	endfunction

	task automatic send_frame(input logic [31:0] ts, input int npk, input bit closed);
		int hbits;
		int plen;
		int sel;
		for (int p = 0; p < npk; p++) begin
			sel = $urandom_range(0, 9);
			hbits = (sel < 2) ? 0 : (sel < 9) ? $urandom_range(1, 40) : $urandom_range(41, 300);
			plen = $urandom_range(0, 16);
			send_packet(16'(hbits), HDR_LEN_BYTES + (hbits + BIT_ROUND_UP) / BITS_PER_BYTE + plen,
				closed && p == npk - 1, ts);
		end
	endtask

	task automatic send_stray(input int n);
		for (int i = 0; i < n; i++)
			send_byte(8'($urandom), 1'b0, 1'($urandom), 1'($urandom), last_ts);
	endtask

	task automatic random_traffic(input int n_items);
		int stop_at;
		int pick;
		stop_at = sent_cnt + n_items;
		while (sent_cnt < stop_at) begin
			if (!quiet)
				gap_pct = 10 * $urandom_range(0, 2);
			pick = $urandom_range(0, 99);
			if (pick < 70)
				send_frame(next_ts(), $urandom_range(1, 3), 1'b1);
			else if (pick < 82)
				send_frame(next_ts(), $urandom_range(1, 2), 1'b0);
			else if (pick < 92)
				send_packet(16'($urandom), $urandom_range(1, 3), 1'($urandom), next_ts());
			else
				send_stray($urandom_range(1, 4));
		end
	endtask

	task automatic wait_drained();
		pkt_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		arst_n <= 1'b0;
		pkt_ch.valid <= 1'b0;
		pkt_ch.item <= '0;
		sent_cnt = 0;
		gap_pct = 10;
		quiet = 1'b0;
		hold_req = 1'b0;
		last_ts = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain frame, extreme data and timestamp zero
		send_byte(8'h00, 1'b1, 1'b0, 1'b1, 32'h0000_0000);
		send_byte(8'h00, 1'b0, 1'b0, 1'b1, 32'h0000_0000);
		send_byte(8'hFF, 1'b0, 1'b0, 1'b1, 32'h0000_0000);
		send_byte(8'h00, 1'b0, 1'b1, 1'b1, 32'h0000_0000);
		// unfinished frame, then abort by a short marked packet ending in its header
		send_packet(16'd16, 6, 1'b0, 32'h1234_5678);
		send_packet(16'd8, 2, 1'b1, 32'hFFFF_FFFF);
		// abort and frame end on one single-byte packet
		send_packet(16'd0, 3, 1'b0, 32'h0000_0001);
		send_byte(8'h00, 1'b1, 1'b1, 1'b1, 32'h0000_0002);
		// bytes without packet start after a packet end
		send_byte(8'hA5, 1'b0, 1'b0, 1'b0, 32'h0000_0002);
		send_byte(8'h5A, 1'b0, 1'b1, 1'b1, 32'h0000_0002);
		send_packet(16'd1, 5, 1'b0, 32'h0000_0003);
		send_byte(8'h3C, 1'b0, 1'b0, 1'b1, 32'h0000_0003);
		send_byte(8'hC3, 1'b0, 1'b1, 1'b1, 32'h0000_0003);
		// header longer than the packet
		send_packet(16'hFFFF, 3, 1'b1, 32'h0000_0004);

		random_traffic(400);

		// output held off while input keeps coming
		hold_req = 1'b1;
		send_packet(16'd0, 60, 1'b1, next_ts());
		wait_drained();

		// long packet, then continue it without a start
		gap_pct = 5;
		send_packet(16'd8, 120, 1'b1, next_ts());
		send_stray(3);
		send_byte(8'($urandom), 1'b0, 1'b1, 1'b1, last_ts);

		random_traffic(300);

		quiet = 1'b1;
		gap_pct = 0;
		random_traffic(200);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tb: success");
		end else begin
			if (sb.pending.size() != 0)
				$display("%0t: %0d expected results never arrived", $time, sb.pending.size());
			$display("tb: failure");
		end
		$finish;
	end

endmodule
